@@ rtl/core/hcd_pkg.sv @@
package hcd_pkg;

    // Field and register widths.
    localparam int BYTE_W = 8;
    localparam int SIZE_W = 24;
    localparam int STATUS_W = 3;

    // Reset value of the chunk size limit.
    localparam logic [SIZE_W-1:0] MAX_CHUNK_RESET = 24'd65536;

    // Depth of the queue between the classifier and the decoder.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

    // Characters of interest on the size line.
    localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UF    = 8'h46;
    localparam logic [BYTE_W-1:0] CHAR_UX    = 8'h58;
    localparam logic [BYTE_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [BYTE_W-1:0] CHAR_LF_HEX = 8'h66;
    localparam logic [BYTE_W-1:0] CHAR_LX    = 8'h78;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_FRAME    = 3'd0,
        ST_PAYLOAD  = 3'd1,
        ST_END      = 3'd2,
        ST_OVERSIZE = 3'd3,
        ST_LONG     = 3'd4
    } t_status;

    // Decoder phase.
    typedef enum logic [1:0] {
        PH_LINE  = 2'd0,
        PH_DATA  = 2'd1,
        PH_TRAIL = 2'd2,
        PH_ERROR = 2'd3
    } t_phase;

    // Progress of the hex number on the size line.
    typedef enum logic [1:0] {
        NUM_BLANK  = 2'd0,
        NUM_ZERO   = 2'd1,
        NUM_DIGITS = 2'd2,
        NUM_STOP   = 2'd3
    } t_num;

    // A classified input byte as it travels from front to back.
    typedef struct packed {
        logic [BYTE_W-1:0] byte_val;
        logic [3:0]        hex_val;
        logic              is_hex;
        logic              is_blank;
        logic              is_zero;
        logic              is_x;
        logic              is_cr;
        logic              is_lf;
    } t_class;

endpackage

@@ rtl/core/hcd_front.sv @@
module hcd_front
    import hcd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_byte,
    output logic              o_q_valid,
    input  logic              i_q_ready,
    output t_class            o_q_item
);

    logic   is_digit;
    logic   is_lower;
    logic   is_upper;
    logic [BYTE_W-1:0] hex_full;
    t_class cls;

    t_class              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic                push;
    logic                pop;

    // Classify the incoming byte for the size line parser.
    always_comb begin
        is_digit = (i_byte >= CHAR_ZERO) && (i_byte <= CHAR_NINE);
        is_lower = (i_byte >= CHAR_LA) && (i_byte <= CHAR_LF_HEX);
        is_upper = (i_byte >= CHAR_UA) && (i_byte <= CHAR_UF);
        if (is_digit) begin
            hex_full = i_byte - CHAR_ZERO;
        end else if (is_lower) begin
            hex_full = i_byte - CHAR_LA + 8'd10;
        end else begin
            hex_full = i_byte - CHAR_UA + 8'd10;
        end
        cls.byte_val = i_byte;
        cls.hex_val  = hex_full[3:0];
        cls.is_hex   = is_digit || is_lower || is_upper;
        cls.is_blank = (i_byte == CHAR_SPACE) ||
                       ((i_byte >= CHAR_TAB) && (i_byte <= CHAR_CR));
        cls.is_zero  = (i_byte == CHAR_ZERO);
        cls.is_x     = (i_byte == CHAR_LX) || (i_byte == CHAR_UX);
        cls.is_cr    = (i_byte == CHAR_CR);
        cls.is_lf    = (i_byte == CHAR_LF);
    end

    // Queue handshake on both sides.
    assign o_ready   = (r_count != QUEUE_CW'(QUEUE_DEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_count != '0);
    assign pop       = o_q_valid && i_q_ready;
    assign o_q_item  = r_mem[r_rd_ptr];

    // Queue storage; entries need no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= cls;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/hcd_back.sv @@
module hcd_back
    import hcd_pkg::*;
#(
    parameter int HEADER_LIMIT = 31
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_wdata,
    input  logic              i_q_valid,
    output logic              o_q_ready,
    input  t_class            i_q_item,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [BYTE_W-1:0] o_payload,
    output t_status           o_status,
    output logic              o_last
);

    localparam int LEN_W = $clog2(HEADER_LIMIT + 1);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(HEADER_LIMIT);

    logic [SIZE_W-1:0] r_max_size;

    t_phase            r_phase, n_phase;
    logic [SIZE_W-1:0] r_remain, n_remain;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [SIZE_W-1:0] r_acc, n_acc;
    logic              r_ovf, n_ovf;
    t_num              r_num, n_num;
    logic              r_prev_cr, n_prev_cr;
    logic              r_trail, n_trail;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_payload, n_out_payload;
    t_status           r_out_status, n_out_status;
    logic              r_out_last, n_out_last;

    t_num              f_num;
    logic [SIZE_W-1:0] f_acc;
    logic              f_ovf;
    logic [LEN_W-1:0]  len_inc;
    logic [SIZE_W-1:0] remain_dec;
    logic              take;

    // An item is taken whenever the output register is free or draining.
    assign take      = i_q_valid && (!r_out_valid || i_ready);
    assign o_q_ready = (!r_out_valid || i_ready);
    assign len_inc   = r_len + 1'b1;
    assign remain_dec = r_remain - SIZE_W'(r_remain != '0);

    // Size limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size <= MAX_CHUNK_RESET;
        end else if (i_cfg_we) begin
            r_max_size <= i_cfg_wdata;
        end
    end

    // Hex number reader: one character of the size line.
    always_comb begin
        f_num = r_num;
        f_acc = r_acc;
        f_ovf = r_ovf;
        case (r_num)
            NUM_BLANK: begin
                if (i_q_item.is_blank) begin
                    f_num = NUM_BLANK;
                end else if (i_q_item.is_zero) begin
                    f_num = NUM_ZERO;
                end else if (i_q_item.is_hex) begin
                    f_acc = {r_acc[SIZE_W-5:0], i_q_item.hex_val};
                    f_ovf = r_ovf || (r_acc[SIZE_W-1:SIZE_W-4] != '0);
                    f_num = NUM_DIGITS;
                end else begin
                    f_num = NUM_STOP;
                end
            end
            NUM_ZERO: begin
                if (i_q_item.is_x) begin
                    f_num = NUM_DIGITS;
                end else if (i_q_item.is_hex) begin
                    f_acc = {r_acc[SIZE_W-5:0], i_q_item.hex_val};
                    f_ovf = r_ovf || (r_acc[SIZE_W-1:SIZE_W-4] != '0);
                    f_num = NUM_DIGITS;
                end else begin
                    f_num = NUM_STOP;
                end
            end
            NUM_DIGITS: begin
                if (i_q_item.is_hex) begin
                    f_acc = {r_acc[SIZE_W-5:0], i_q_item.hex_val};
                    f_ovf = r_ovf || (r_acc[SIZE_W-1:SIZE_W-4] != '0);
                end else begin
                    f_num = NUM_STOP;
                end
            end
            default: begin
                f_num = NUM_STOP;
            end
        endcase
    end

    // Decoder next state and result.
    always_comb begin
        n_phase       = r_phase;
        n_remain      = r_remain;
        n_len         = r_len;
        n_acc         = r_acc;
        n_ovf         = r_ovf;
        n_num         = r_num;
        n_prev_cr     = r_prev_cr;
        n_trail       = r_trail;
        n_out_payload = '0;
        n_out_status  = ST_FRAME;
        n_out_last    = 1'b0;
        case (r_phase)
            PH_LINE: begin
                if (r_prev_cr && i_q_item.is_lf) begin
                    // End of the size line: start a fresh line either way.
                    n_len     = '0;
                    n_acc     = '0;
                    n_ovf     = 1'b0;
                    n_num     = NUM_BLANK;
                    n_prev_cr = 1'b0;
                    if (r_ovf || (r_acc > r_max_size)) begin
                        n_phase      = PH_ERROR;
                        n_trail      = 1'b0;
                        n_out_status = ST_OVERSIZE;
                    end else if (r_acc == '0) begin
                        n_out_status = ST_END;
                    end else begin
                        n_remain = r_acc;
                        n_phase  = PH_DATA;
                    end
                end else begin
                    n_len     = len_inc;
                    n_acc     = f_acc;
                    n_ovf     = f_ovf;
                    n_num     = f_num;
                    n_prev_cr = i_q_item.is_cr;
                    if (len_inc == LEN_LIMIT) begin
                        n_phase      = PH_ERROR;
                        n_trail      = 1'b1;
                        n_out_status = ST_LONG;
                    end
                end
            end
            PH_DATA: begin
                n_out_status  = ST_PAYLOAD;
                n_out_payload = i_q_item.byte_val;
                n_remain      = remain_dec;
                if (remain_dec == '0) begin
                    n_out_last = 1'b1;
                    n_phase    = PH_TRAIL;
                    n_trail    = 1'b0;
                end
            end
            PH_TRAIL: begin
                if (!r_trail) begin
                    n_trail = 1'b1;
                end else begin
                    n_trail   = 1'b0;
                    n_phase   = PH_LINE;
                    n_len     = '0;
                    n_acc     = '0;
                    n_ovf     = 1'b0;
                    n_num     = NUM_BLANK;
                    n_prev_cr = 1'b0;
                end
            end
            default: begin
                n_out_status = r_trail ? ST_LONG : ST_OVERSIZE;
            end
        endcase
    end

    // Decoder state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LINE;
            r_remain  <= '0;
            r_len     <= '0;
            r_acc     <= '0;
            r_ovf     <= 1'b0;
            r_num     <= NUM_BLANK;
            r_prev_cr <= 1'b0;
            r_trail   <= 1'b0;
        end else if (take) begin
            r_phase   <= n_phase;
            r_remain  <= n_remain;
            r_len     <= n_len;
            r_acc     <= n_acc;
            r_ovf     <= n_ovf;
            r_num     <= n_num;
            r_prev_cr <= n_prev_cr;
            r_trail   <= n_trail;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_payload <= n_out_payload;
            r_out_status  <= n_out_status;
            r_out_last    <= n_out_last;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_payload = r_out_payload;
    assign o_status  = r_out_status;
    assign o_last    = r_out_last;

endmodule

@@ rtl/core/http_chunked_body_decoder_unit.sv @@
// Chunked body decoder: one result item for every byte item taken in.
// An accepted input byte passes first through the classifier queue and then
// through the decoder's output register before it appears at the output.
// Throughput is one byte per cycle while the output is not stalled.
// Reset is synchronous and active low; it clears the queue, the decoder state and
// the error, and loads the chunk size limit with 65536.
module http_chunked_body_decoder_unit
    import hcd_pkg::*;
#(
    parameter int HEADER_LIMIT = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [SIZE_W-1:0]   i_cfg_wdata,   // max_chunk_size
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [BYTE_W-1:0]   i_s_axis_tdata,  // [7:0] stream_byte
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [BYTE_W-1:0]   o_m_axis_tdata,  // [7:0] payload_byte
    output logic [STATUS_W-1:0] o_m_axis_tuser,  // [2:0] status
    output logic                o_m_axis_tlast   // chunk_end
);

    logic    q_valid;
    logic    q_ready;
    t_class  q_item;
    t_status out_status;

    // Front: classify bytes and queue them.
    hcd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_byte    (i_s_axis_tdata),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_item  (q_item)
    );

    // Back: run the chunk framing and register the result.
    hcd_back #(
        .HEADER_LIMIT (HEADER_LIMIT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .o_q_ready   (q_ready),
        .i_q_item    (q_item),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_payload   (o_m_axis_tdata),
        .o_status    (out_status),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = out_status;

    // A queued item reaches an empty output register in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && !o_m_axis_tvalid) |=> o_m_axis_tvalid)
        else $error("queued item did not reach the output register");

    // The end of a chunk is only ever marked on a payload item.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (out_status == ST_PAYLOAD))
        else $error("chunk end flagged on a non-payload item");

    // Non-payload items carry a zero data byte.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (out_status != ST_PAYLOAD)) |-> (o_m_axis_tdata == '0))
        else $error("data byte set on a non-payload item");

    // Input backpressure only happens while the queue holds items.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> q_valid)
        else $error("input stalled with an empty queue");

endmodule
